>>> rtl/assert_macros.svh
// assertion helpers for the clocked checks at the end of a module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// a condition that implies something at the next clock edge
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/mtfr_pkg.sv
// ----------------------------------------------------------------------------
// mtfr_pkg
// widths, constants and types of the modbus tcp frame recogniser
// ----------------------------------------------------------------------------
`default_nettype none

package mtfr_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 4096;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned END_W   = 14;
  localparam int unsigned LABEL_W = 9;
  localparam int unsigned HDR_W   = 56;
  localparam int unsigned PROBE_W = 8;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 40;

  localparam logic [POS_W-1:0]   MIN_PAYLOAD   = 13'd9;
  localparam logic [POS_W-1:0]   MAX_FIRST_PKT = 13'd260;
  localparam logic [LABEL_W-1:0] MODBUS_LABEL  = 9'd502;
  localparam logic [15:0]        LDAP_MASK     = 16'hFF80;
  localparam logic [15:0]        LDAP_TAG      = 16'h3080;
  localparam logic [7:0]         BER_INT_TAG   = 8'h02;
  localparam logic [7:0]         FC_MAX        = 8'd127;
  localparam logic [7:0]         EXC_MIN       = 8'd1;
  localparam logic [7:0]         EXC_MAX       = 8'd12;
  localparam logic [POS_W-1:0]   POS_SAT       = '1;

  // results caused by one payload byte
  typedef struct packed {
    logic               has_rep;
    logic [POS_W-1:0]   pdu_start;
    logic [END_W-1:0]   pdu_end;
    logic               has_ver;
    logic [LABEL_W-1:0] label;
  } res_entry_t;

endpackage

`default_nettype wire

>>> rtl/modbus_tcp_frame_recognizer_core.sv
// ----------------------------------------------------------------------------
// modbus_tcp_frame_recognizer_core
// rebuilds modbus tcp mbap headers from a payload byte stream, reports
// accepted frames and gives a 502 or 0 verdict on the last byte
// ----------------------------------------------------------------------------
// One payload byte is taken per clock cycle. Each byte is checked in the cycle
// it is accepted and its results (a frame report, a verdict, or both) go into a
// two-entry result queue; a byte that causes both results hands out two output
// transfers from one entry. The input stalls only when that queue is full.
// There is no start-up pass after reset. The scan_all_frames register is
// written over the cfg channel and may only change while no item is in flight.
`default_nettype none

`include "assert_macros.svh"

module modbus_tcp_frame_recognizer_core #(
  parameter int unsigned PAYLOAD_MAX = mtfr_pkg::PAYLOAD_MAX_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic                       cfg_data_i,     // scan_all_frames
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [mtfr_pkg::IN_W-1:0]  s_axis_tdata_i, // data_byte, payload_length,
                                                          // first_boundary
  input  wire logic                       s_axis_tlast_i, // last_byte
  input  wire logic                       s_axis_tuser_i, // is_tcp
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [mtfr_pkg::OUT_W-1:0]      m_axis_tdata_o, // pdu_start, pdu_end, app_label
  output logic                            m_axis_tlast_o, // run_last
  output logic                            m_axis_tuser_o  // result_kind
);

  localparam int unsigned PW = mtfr_pkg::POS_W;
  localparam logic [16:0] PayloadMaxW = 17'(PAYLOAD_MAX);

  logic scan_all_q;

  logic [PW-1:0]                pos_q, pos_d;
  logic [PW-1:0]                fs_q, fs_d;
  logic [mtfr_pkg::HDR_W-1:0]   hdr_q, hdr_d;
  logic [PW-1:0]                nacc_q, nacc_d;
  logic [mtfr_pkg::PROBE_W-1:0] probe_q, probe_d;
  logic                         fz_q, fz_d;
  logic                         stop_q, stop_d;

  mtfr_pkg::res_entry_t fifo_q [2];
  mtfr_pkg::res_entry_t ent_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       sub_q;

  logic [7:0]    b;
  logic [PW-1:0] len, fb, pkt;
  logic          in_hs, out_hs, pop, push, pre_ok;

  logic [PW-1:0]                r;
  logic [mtfr_pkg::HDR_W-1:0]   hdr_new;
  logic [15:0]                  trans, proto, flen;
  logic [mtfr_pkg::PROBE_W-1:0] q;
  logic [7:0]                   pb;
  logic [17:0]                  nxt;
  logic                         accept;

  assign b   = s_axis_tdata_i[7:0];
  assign len = s_axis_tdata_i[20:8];
  assign fb  = s_axis_tdata_i[33:21];
  assign pkt = (fb == '0) ? '0 : ((fb < len) ? fb : len);

  assign pre_ok = s_axis_tuser_i && (len >= mtfr_pkg::MIN_PAYLOAD) &&
                  (pkt <= mtfr_pkg::MAX_FIRST_PKT) && ({4'b0, len} <= PayloadMaxW);

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign in_hs           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    pos_d   = pos_q;
    fs_d    = fs_q;
    hdr_d   = hdr_q;
    nacc_d  = nacc_q;
    probe_d = probe_q;
    fz_d    = fz_q;
    stop_d  = stop_q;
    r       = pos_q - fs_q;
    hdr_new = {hdr_q[mtfr_pkg::HDR_W-9:0], b};
    trans   = hdr_new[55:40];
    proto   = hdr_new[39:24];
    flen    = hdr_q[23:8];
    q       = trans[7:0] & 8'h7F;
    q       = q + 8'd2;
    pb      = 8'h00;
    nxt     = {5'b0, fs_q} + {2'b0, hdr_q[23:8]} + 18'd6;
    accept  = 1'b0;
    ent_d   = '0;

    unique case (q[2:0])
      3'd2:    pb = hdr_new[39:32];
      3'd3:    pb = hdr_new[31:24];
      3'd4:    pb = hdr_new[23:16];
      3'd5:    pb = hdr_new[15:8];
      3'd6:    pb = hdr_new[7:0];
      default: pb = 8'h00;
    endcase

    if (!pre_ok) begin
      stop_d  = 1'b1;
      probe_d = '0;
    end else begin
      if (probe_q != '0 && pos_q == {5'b0, probe_q}) begin
        if (b == mtfr_pkg::BER_INT_TAG) begin
          fz_d   = 1'b1;
          stop_d = 1'b1;
        end
        probe_d = '0;
      end
      if (!stop_d && pos_q >= fs_q) begin
        if (r < 13'd7) begin
          hdr_d = hdr_new;
        end
        if (r == 13'd6) begin
          flen = hdr_new[23:8];
          if (({1'b0, fs_q} + 14'd9) > {1'b0, len}) begin
            stop_d = 1'b1;
          end else if (trans == {3'b0, pkt}) begin
            fz_d   = 1'b1;
            stop_d = 1'b1;
          end else begin
            if (nacc_q == '0 && (trans & mtfr_pkg::LDAP_MASK) == mtfr_pkg::LDAP_TAG) begin
              if ({5'b0, q} < len) begin
                if (q <= 8'd6) begin
                  if (pb == mtfr_pkg::BER_INT_TAG) begin
                    fz_d   = 1'b1;
                    stop_d = 1'b1;
                  end
                end else begin
                  probe_d = q;
                end
              end
            end
            if (!stop_d) begin
              if (proto != '0 || flen < 16'd3 ||
                  ({4'b0, fs_q} + 17'd6 + {1'b0, flen}) > {4'b0, len}) begin
                stop_d = 1'b1;
              end else if (nacc_q == '0 && ({1'b0, flen} + 17'd6) != {4'b0, pkt}) begin
                fz_d   = 1'b1;
                stop_d = 1'b1;
              end
            end
          end
        end else if (r == 13'd7) begin
          accept = (b <= mtfr_pkg::FC_MAX);
        end else if (r == 13'd8) begin
          if (b >= mtfr_pkg::EXC_MIN && b <= mtfr_pkg::EXC_MAX) begin
            accept = 1'b1;
          end else begin
            stop_d = 1'b1;
          end
        end else if (r > 13'd8) begin
          stop_d = 1'b1;
        end
        if (accept) begin
          ent_d.has_rep   = 1'b1;
          ent_d.pdu_start = fs_q + 13'd7;
          ent_d.pdu_end   = nxt[mtfr_pkg::END_W-1:0];
          if (nacc_q != mtfr_pkg::POS_SAT) begin
            nacc_d = nacc_q + 13'd1;
          end
          if (!scan_all_q || (nxt + 18'd9) > {5'b0, len}) begin
            stop_d = 1'b1;
          end else begin
            fs_d = nxt[PW-1:0];
          end
        end
      end
    end

    if (pos_q != mtfr_pkg::POS_SAT) begin
      pos_d = pos_q + 13'd1;
    end

    if (s_axis_tlast_i) begin
      ent_d.has_ver = 1'b1;
      ent_d.label   = (pre_ok && !fz_d && nacc_d != '0) ? mtfr_pkg::MODBUS_LABEL : '0;
      pos_d   = '0;
      fs_d    = '0;
      hdr_d   = '0;
      nacc_d  = '0;
      probe_d = '0;
      fz_d    = 1'b0;
      stop_d  = 1'b0;
    end
  end

  assign push = in_hs && (ent_d.has_rep || ent_d.has_ver);

  // output side of the result queue
  mtfr_pkg::res_entry_t head;
  logic                 show_rep;

  assign head            = fifo_q[rd_ptr_q];
  assign show_rep        = head.has_rep && !sub_q;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tuser_o  = !show_rep;
  assign m_axis_tlast_o  = !(show_rep && head.has_ver);
  assign m_axis_tdata_o  = show_rep ?
      {4'b0, {mtfr_pkg::LABEL_W{1'b0}}, head.pdu_end, head.pdu_start} :
      {4'b0, head.label, {mtfr_pkg::END_W{1'b0}}, {PW{1'b0}}};
  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;
  assign pop    = out_hs && m_axis_tlast_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= ent_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_all_q <= 1'b1;
      pos_q      <= '0;
      fs_q       <= '0;
      hdr_q      <= '0;
      nacc_q     <= '0;
      probe_q    <= '0;
      fz_q       <= 1'b0;
      stop_q     <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
      sub_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        scan_all_q <= cfg_data_i;
      end
      if (in_hs) begin
        pos_q   <= pos_d;
        fs_q    <= fs_d;
        hdr_q   <= hdr_d;
        nacc_q  <= nacc_d;
        probe_q <= probe_d;
        fz_q    <= fz_d;
        stop_q  <= stop_d;
      end
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_hs) begin
        sub_q <= !m_axis_tlast_o;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, cnt_q != 2'd3, "result queue overfilled")
  `ASSERT_ALWAYS(a_sub_on_verdict, !sub_q || (cnt_q != 2'd0 && head.has_ver && head.has_rep), "second result phase without a verdict")
  `ASSERT_NEXT(a_payload_clear, in_hs && s_axis_tlast_i, pos_q == '0 && nacc_q == '0, "state not cleared after last byte")

endmodule

`default_nettype wire

>>> tb/mbap_result_checker.sv
// ----------------------------------------------------------------------------
// mbap_result_checker
// watches the config, payload and result channels of the modbus tcp frame
// recogniser, predicts the frame reports and verdicts of every accepted byte
// and compares them in order with the results the block hands out
// ----------------------------------------------------------------------------
`default_nettype none

module mbap_result_checker import mtfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_ready_i,
  input  wire logic             cfg_data_i,
  input  wire logic             s_tvalid_i,
  input  wire logic             s_tready_i,
  input  wire logic [IN_W-1:0]  s_tdata_i,
  input  wire logic             s_tlast_i,
  input  wire logic             s_tuser_i,
  input  wire logic             m_tvalid_i,
  input  wire logic             m_tready_i,
  input  wire logic [OUT_W-1:0] m_tdata_i,
  input  wire logic             m_tlast_i,
  input  wire logic             m_tuser_i,
  output int unsigned           err_cnt_o,
  output int unsigned           pending_o
);

  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   pdu_start;
    logic [END_W-1:0]   pdu_end;
    logic [LABEL_W-1:0] label;
    logic               last;
  } mb_result_t;

  mb_result_t     exp_q[$];
  int unsigned    err_cnt;

  // per payload scan state
  logic           scan_all;
  int unsigned    byte_pos;
  int unsigned    frame_at;
  logic [HDR_W-1:0] hdr;
  int unsigned    n_frames;
  int unsigned    probe_at;
  logic           forced_zero;
  logic           scan_stopped;

  task automatic clear_payload_state();
    byte_pos     = 0;
    frame_at     = 0;
    hdr          = '0;
    n_frames     = 0;
    probe_at     = 0;
    forced_zero  = 1'b0;
    scan_stopped = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic is_last,
                              input logic [POS_W-1:0] len_in, input logic tcp,
                              input logic [POS_W-1:0] fb_in);
    int unsigned len_pl, fb, pkt, p, r, flen, q, nxt;
    logic [15:0] trans, proto;
    logic        pre_ok, accept, has_rep;
    mb_result_t  rep, ver;
    len_pl  = len_in;
    fb      = fb_in;
    pkt     = (fb == 0) ? 0 : ((fb < len_pl) ? fb : len_pl);
    pre_ok  = tcp && len_pl >= MIN_PAYLOAD && pkt <= MAX_FIRST_PKT &&
              len_pl <= PAYLOAD_MAX_DEF;
    p       = byte_pos;
    accept  = 1'b0;
    has_rep = 1'b0;
    rep     = '0;
    ver     = '0;
    if (!pre_ok) begin
      scan_stopped = 1'b1;
      probe_at     = 0;
    end else begin
      // pending ldap probe byte
      if (probe_at != 0 && p == probe_at) begin
        if (b == BER_INT_TAG) begin
          forced_zero  = 1'b1;
          scan_stopped = 1'b1;
        end
        probe_at = 0;
      end
      if (!scan_stopped && p >= frame_at) begin
        r    = p - frame_at;
        flen = hdr[23:8];
        if (r < 7) hdr = {hdr[HDR_W-9:0], b};
        if (r == 6) begin
          trans = hdr[55:40];
          proto = hdr[39:24];
          flen  = hdr[23:8];
          if (frame_at + 9 > len_pl) begin
            scan_stopped = 1'b1;
          end else if (trans == pkt) begin
            // looks like tns
            forced_zero  = 1'b1;
            scan_stopped = 1'b1;
          end else begin
            if (n_frames == 0 && (trans & LDAP_MASK) == LDAP_TAG) begin
              q = trans[6:0] + 2;
              if (q < len_pl) begin
                if (q <= 6) begin
                  if (hdr[(6 - q) * 8 +: 8] == BER_INT_TAG) begin
                    forced_zero  = 1'b1;
                    scan_stopped = 1'b1;
                  end
                end else begin
                  probe_at = q;
                end
              end
            end
            if (!scan_stopped) begin
              if (proto != 0 || flen < 3 || frame_at + 6 + flen > len_pl) begin
                scan_stopped = 1'b1;
              end else if (n_frames == 0 && flen + 6 != pkt) begin
                forced_zero  = 1'b1;
                scan_stopped = 1'b1;
              end
            end
          end
        end else if (r == 7) begin
          if (b <= FC_MAX) accept = 1'b1;
        end else if (r == 8) begin
          if (b >= EXC_MIN && b <= EXC_MAX) accept = 1'b1;
          else scan_stopped = 1'b1;
        end else if (r > 8) begin
          scan_stopped = 1'b1;
        end
        if (accept) begin
          nxt           = frame_at + flen + 6;
          has_rep       = 1'b1;
          rep.kind      = KIND_FRAME;
          rep.pdu_start = POS_W'(frame_at + 7);
          rep.pdu_end   = END_W'(nxt);
          if (n_frames < POS_SAT) n_frames++;
          if (!scan_all || nxt + 9 > len_pl) scan_stopped = 1'b1;
          else frame_at = nxt;
        end
      end
    end
    if (byte_pos < POS_SAT) byte_pos++;
    if (has_rep) begin
      rep.last = !is_last;
      exp_q.push_back(rep);
    end
    if (is_last) begin
      ver.kind  = KIND_VERDICT;
      ver.label = (pre_ok && !forced_zero && n_frames > 0) ? MODBUS_LABEL : '0;
      ver.last  = 1'b1;
      exp_q.push_back(ver);
      clear_payload_state();
    end
  endtask

  task automatic check_result(input mb_result_t got);
    mb_result_t want;
    if (exp_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result: kind %0d start %0d end %0d label %0d last %0d",
                 got.kind, got.pdu_start, got.pdu_end, got.label, got.last);
    end else begin
      want = exp_q.pop_front();
      if (got.kind !== want.kind || got.pdu_start !== want.pdu_start ||
          got.pdu_end !== want.pdu_end || got.label !== want.label ||
          got.last !== want.last) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("result mismatch: expected kind %0d start %0d end %0d label %0d last %0d,",
                   want.kind, want.pdu_start, want.pdu_end, want.label, want.last,
                   " got kind %0d start %0d end %0d label %0d last %0d",
                   got.kind, got.pdu_start, got.pdu_end, got.label, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_all = 1'b1;
      clear_payload_state();
      exp_q.delete();
      err_cnt = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) scan_all = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        predict_byte(s_tdata_i[7:0], s_tlast_i, s_tdata_i[8 +: POS_W], s_tuser_i,
                     s_tdata_i[8 + POS_W +: POS_W]);
      if (m_tvalid_i && m_tready_i)
        check_result({m_tuser_i, m_tdata_i[0 +: POS_W], m_tdata_i[POS_W +: END_W],
                      m_tdata_i[POS_W + END_W +: LABEL_W], m_tlast_i});
      err_cnt_o <= err_cnt;
      pending_o <= exp_q.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_modbus_tcp_frame_recognizer_core.sv
// ----------------------------------------------------------------------------
// tb_modbus_tcp_frame_recognizer_core
// drives payload byte streams into the modbus tcp frame recogniser: a few
// directed payloads, then mostly well-formed multi-frame payloads with random
// content and corruptions, plus noise, under both scan modes, with random
// gaps on both sides and a long output hold; a checker compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modbus_tcp_frame_recognizer_core;
  import mtfr_pkg::*;

  localparam int unsigned SETTLE_CYC = 4;
  localparam int unsigned HOLD_CYC   = 80;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data  = 1'b0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;
  logic              s_tlast   = 1'b0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;
  logic              m_tuser;
  int unsigned       err_cnt;
  int unsigned       pending;

  // current payload
  logic [7:0]        pl_q[$];
  logic [POS_W-1:0]  pl_len;
  logic [POS_W-1:0]  pl_fb;
  logic              pl_tcp;

  int unsigned       n_sent  = 0;
  int unsigned       pld_cnt = 0;
  logic              quiet   = 1'b0;
  logic              hold_req = 1'b0;

  modbus_tcp_frame_recognizer_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  mbap_result_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .m_tuser_i   (m_tuser),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, occasionally a long hold
  initial begin
    int unsigned n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end else begin
        n = quiet ? 0 : $urandom_range(0, 6);
        if (n != 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - 2 * POS_W - 8){1'b0}}, pl_fb, pl_len, b};
    s_tlast  <= lst;
    s_tuser  <= pl_tcp;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  task automatic send_payload();
    int unsigned i;
    for (i = 0; i < pl_q.size(); i++) send_byte(pl_q[i], i == pl_q.size() - 1);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_scan_mode(input logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_payload(input logic modbus);
    int unsigned nfr, f, i, flen, f0_len, n, k;
    logic [15:0] trans;
    logic [7:0]  fc;
    pl_q.delete();
    pl_tcp = 1'b1;
    if (!modbus) begin
      n = $urandom_range(1, 24);
      repeat (n) pl_q.push_back(8'($urandom));
      pl_len = ($urandom_range(0, 2) == 0) ? POS_W'($urandom_range(0, 12)) :
                                             POS_W'($urandom_range(0, 4096));
      pl_fb  = ($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, 300)) :
                                             POS_W'($urandom_range(0, 4096));
      pl_tcp = ($urandom_range(0, 3) != 0);
    end else begin
      nfr    = $urandom_range(1, 4);
      f0_len = 0;
      for (f = 0; f < nfr; f++) begin
        case ($urandom_range(0, 29))
          0:       flen = $urandom_range(11, 254);
          1, 2:    flen = $urandom_range(11, 40);
          default: flen = $urandom_range(3, 10);
        endcase
        if (f == 0) f0_len = flen + 6;
        trans = 16'($urandom);
        fc    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255)) :
                                              8'($urandom_range(0, 127));
        pl_q.push_back(trans[15:8]);
        pl_q.push_back(trans[7:0]);
        pl_q.push_back(8'h00);
        pl_q.push_back(8'h00);
        pl_q.push_back(8'(flen >> 8));
        pl_q.push_back(8'(flen));
        pl_q.push_back(8'($urandom));
        pl_q.push_back(fc);
        if (fc > FC_MAX && $urandom_range(0, 9) != 0)
          pl_q.push_back(8'($urandom_range(EXC_MIN, EXC_MAX)));
        else
          pl_q.push_back(8'($urandom));
        for (i = 3; i < flen; i++) pl_q.push_back(8'($urandom));
      end
      pl_len = POS_W'(pl_q.size());
      pl_fb  = POS_W'(f0_len);
      case ($urandom_range(0, 13))
        0: begin
          // transaction id equal to the first packet length
          pl_q[0] = 8'(pl_fb >> 8);
          pl_q[1] = pl_fb[7:0];
        end
        1, 2: begin
          // ldap style transaction id, probe byte sometimes a ber integer tag
          k = $urandom_range(0, (pl_q.size() < 130) ? pl_q.size() - 1 : 127);
          pl_q[0] = LDAP_TAG[15:8];
          pl_q[1] = {1'b1, 7'(k)};
          if (k + 2 < pl_q.size() && $urandom_range(0, 1) == 0) pl_q[k + 2] = BER_INT_TAG;
        end
        3: pl_q[$urandom_range(0, pl_q.size() - 1)] = 8'($urandom);
        4: pl_q[$urandom_range(2, 3)] = 8'($urandom_range(1, 255));
        5: pl_q[5] = 8'($urandom);
        6: begin
          n = $urandom_range(1, 6);
          repeat (n) pl_q.push_back(8'($urandom));
          pl_len = POS_W'(pl_q.size());
        end
        7: pl_len = POS_W'(pl_q.size() + $urandom_range(1, 4));
        8: pl_len = POS_W'(pl_q.size() - $urandom_range(1, 4));
        9: begin
          case ($urandom_range(0, 2))
            0:       pl_fb = '0;
            1:       pl_fb = POS_W'($urandom_range(pl_len, 4096));
            default: pl_fb = POS_W'($urandom_range(0, 4096));
          endcase
        end
        10: pl_tcp = 1'b0;
        default: ;
      endcase
    end
  endtask

  task automatic run_random(input int unsigned target);
    logic modbus;
    while (n_sent < target) begin
      quiet  = ($urandom_range(0, 4) == 0);
      modbus = ($urandom_range(0, 4) != 0);
      if (pld_cnt % 40 == 7) hold_req = 1'b1;
      build_payload(modbus);
      send_payload();
      pld_cnt++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // minimal frame, all-ones fields around a zero function code
    pl_q   = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h00, 8'hFF};
    pl_len = 13'd9;
    pl_fb  = 13'd9;
    pl_tcp = 1'b1;
    send_payload();
    // exception response at the top code, boundary clipped to the payload
    pl_q   = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h80, EXC_MAX};
    pl_fb  = 13'd4096;
    send_payload();
    // not tcp, largest payload length
    pl_q   = '{8'hFF};
    pl_len = 13'd4096;
    pl_fb  = '0;
    pl_tcp = 1'b0;
    send_payload();
    // zero payload length
    pl_q   = '{8'h00};
    pl_len = '0;
    pl_tcp = 1'b1;
    send_payload();

    set_scan_mode(1'b0);
    run_random(500);
    set_scan_mode(1'b1);
    run_random(950);
    set_scan_mode(1'b0);
    run_random(1150);
    set_scan_mode(1'b1);
    run_random(1450);
    wait_idle();

    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
